### rtl/cbmm_pkg.sv
// Shared types, codes and defaults for the CPU bus memory map.
package cbmm_pkg;

   // Default sizes of the work RAM and of one program ROM bank.
   localparam int RAM_BYTES_DEFAULT  = 2048;
   localparam int BANK_BYTES_DEFAULT = 16384;

   // Transaction kinds.
   localparam logic [2:0] KIND_READ_BYTE   = 3'd0;
   localparam logic [2:0] KIND_WRITE_BYTE  = 3'd1;
   localparam logic [2:0] KIND_READ_SHORT  = 3'd2;
   localparam logic [2:0] KIND_WRITE_SHORT = 3'd3;
   localparam logic [2:0] KIND_LOAD_ROM    = 3'd4;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_PPU       = 2'd1;
   localparam logic [1:0] STATUS_ROM_WRITE = 2'd2;
   localparam logic [1:0] STATUS_UNMAPPED  = 2'd3;

   // Bank count register.
   localparam logic [1:0] BANKS_RESET = 2'd2;
   localparam logic [1:0] BANKS_ONE   = 2'd1;

   // Upper three address bits of the RAM and PPU windows.
   localparam logic [2:0] WINDOW_RAM = 3'b000;
   localparam logic [2:0] WINDOW_PPU = 3'b001;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;   // write zero to the RAM entry under the clear counter
      logic first;   // transaction accepted, first byte access
      logic second;  // second byte access of a short transaction
      logic finish;  // load the result register
   } cbmm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;    // clear counter at the last RAM entry
      logic needs_second;  // offered transaction needs a second byte access
      logic out_busy;      // result register holds a transaction not yet taken
   } cbmm_stat_type;

endpackage

### rtl/cbmm_ctrl.sv
// Controller state machine of the CPU bus memory map.
module cbmm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cbmm_pkg::cbmm_stat_type stat,
   output cbmm_pkg::cbmm_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SECOND = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd.clear  = 1'b0;
      cmd.first  = 1'b0;
      cmd.second = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.first = 1'b1;
               state_in  = stat.needs_second ? ST_SECOND : ST_FINISH;
            end
         end
         ST_SECOND: begin
            cmd.second = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Transactions are taken only between items.
   assign req_stall = (state_ff != ST_IDLE);

   // State register; reset starts the RAM clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // A result is never written over one that still waits.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !stat.out_busy)
      else $error("result register loaded while busy");

   // A short transaction goes on to its second byte access.
   a_short_second: assert property (@(posedge clock) disable iff (reset)
      (cmd.first && stat.needs_second) |=> (state_ff == ST_SECOND))
      else $error("short transaction skipped its second access");

   // The second access is always followed by the finish step.
   a_second_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SECOND) |=> (state_ff == ST_FINISH))
      else $error("second access not followed by finish");

   // No transaction is accepted while the RAM is being cleared.
   a_clear_no_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (!cmd.first && req_stall))
      else $error("transaction accepted during clearing");

endmodule

### rtl/cbmm_datapath.sv
// Datapath of the CPU bus memory map: decode, RAM, program ROM and result register.
module cbmm_datapath #(
   parameter int RAM_BYTES  = cbmm_pkg::RAM_BYTES_DEFAULT,
   parameter int BANK_BYTES = cbmm_pkg::BANK_BYTES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cbmm_pkg::cbmm_cmd_type  cmd,
   output cbmm_pkg::cbmm_stat_type stat,
   input  logic [2:0]              req_kind,
   input  logic [15:0]             req_address,
   input  logic [15:0]             req_data,
   input  logic [14:0]             req_load_offset,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [15:0]             rsp_read_data,
   output logic [1:0]              rsp_status,
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_write_data
);

   localparam int RAM_AW  = $clog2(RAM_BYTES);
   localparam int ROM_AW  = $clog2(2 * BANK_BYTES);
   localparam logic [ROM_AW-1:0] BANK_MASK = ROM_AW'(BANK_BYTES - 1);
   localparam logic [RAM_AW-1:0] RAM_LAST  = RAM_AW'(RAM_BYTES - 1);

   logic [7:0] work_ram    [RAM_BYTES];
   logic [7:0] program_rom [2 * BANK_BYTES];

   logic [1:0]        banks_ff;
   logic [RAM_AW-1:0] clear_cnt_ff;
   logic [7:0]        ram_q_ff;
   logic [7:0]        rom_q_ff;

   // Transaction context captured at accept.
   logic [1:0]        status_ff;
   logic              ram_rd_ff;
   logic              rom_rd_ff;
   logic              two_ff;
   logic              ram_two_ff;
   logic              rom_two_ff;
   logic              wr_ff;
   logic [RAM_AW-1:0] m1_ff;
   logic [ROM_AW-1:0] o1_ff;
   logic [7:0]        hi_data_ff;
   logic [7:0]        lo_ff;

   logic              rsp_valid_ff;
   logic [15:0]       rsp_read_data_ff;
   logic [1:0]        rsp_status_ff;

   // Decode of the offered transaction.
   logic              is_load;
   logic              is_acc;
   logic              is_wr;
   logic              is_short;
   logic              in_ram;
   logic              in_ppu;
   logic              in_rom;
   logic              ram_rd;
   logic              rom_rd;
   logic [1:0]        status_in;
   logic [RAM_AW-1:0] m0;
   logic [ROM_AW-1:0] o0;
   logic [ROM_AW-1:0] o_plus;
   logic [ROM_AW-1:0] o1;
   logic              one_bank;

   // Memory port controls.
   logic              ram_en;
   logic              ram_we;
   logic [RAM_AW-1:0] ram_addr;
   logic [7:0]        ram_wd;
   logic              rom_en;
   logic              rom_we;
   logic [ROM_AW-1:0] rom_addr;
   logic [7:0]        sel_q;

   assign one_bank = (banks_ff == cbmm_pkg::BANKS_ONE);

   // Kind and address window decode.
   always_comb begin
      is_load  = (req_kind == cbmm_pkg::KIND_LOAD_ROM);
      is_acc   = (req_kind <= cbmm_pkg::KIND_WRITE_SHORT);
      is_wr    = req_kind[0];
      is_short = req_kind[1];
      in_ram   = (req_address[15:13] == cbmm_pkg::WINDOW_RAM);
      in_ppu   = (req_address[15:13] == cbmm_pkg::WINDOW_PPU);
      in_rom   = req_address[15];
      ram_rd   = is_acc && in_ram && !is_wr;
      rom_rd   = is_acc && in_rom && !is_wr;
      if (!is_acc || in_ram) begin
         status_in = cbmm_pkg::STATUS_OK;
      end else if (in_ppu) begin
         status_in = cbmm_pkg::STATUS_PPU;
      end else if (in_rom) begin
         status_in = is_wr ? cbmm_pkg::STATUS_ROM_WRITE : cbmm_pkg::STATUS_OK;
      end else begin
         status_in = cbmm_pkg::STATUS_UNMAPPED;
      end
   end

   // Mirrored RAM offset and ROM offsets, with the second byte wrapping.
   always_comb begin
      m0     = req_address[RAM_AW-1:0];
      o0     = one_bank ? (req_address[ROM_AW-1:0] & BANK_MASK) : req_address[ROM_AW-1:0];
      o_plus = o0 + ROM_AW'(1);
      o1     = one_bank ? (o_plus & BANK_MASK) : o_plus;
   end

   // Memory port selection.
   always_comb begin
      ram_en = cmd.clear || (cmd.first && is_acc && in_ram) || (cmd.second && ram_two_ff);
      ram_we = cmd.clear || (cmd.first && is_acc && in_ram && is_wr) ||
               (cmd.second && ram_two_ff && wr_ff);
      if (cmd.clear) begin
         ram_addr = clear_cnt_ff;
         ram_wd   = 8'h00;
      end else if (cmd.first) begin
         ram_addr = m0;
         ram_wd   = req_data[7:0];
      end else begin
         ram_addr = m1_ff;
         ram_wd   = hi_data_ff;
      end
      rom_en = (cmd.first && (is_load || rom_rd)) || (cmd.second && rom_two_ff);
      rom_we = cmd.first && is_load;
      if (cmd.first) begin
         rom_addr = is_load ? req_load_offset[ROM_AW-1:0] : o0;
      end else begin
         rom_addr = o1_ff;
      end
   end

   // Work RAM with registered read.
   always_ff @(posedge clock) begin
      if (ram_en) begin
         if (ram_we) begin
            work_ram[ram_addr] <= ram_wd;
         end
         ram_q_ff <= work_ram[ram_addr];
      end
   end

   // Program ROM with registered read, loaded by load transactions.
   always_ff @(posedge clock) begin
      if (rom_en) begin
         if (rom_we) begin
            program_rom[rom_addr] <= req_data[7:0];
         end
         rom_q_ff <= program_rom[rom_addr];
      end
   end

   // Byte returned by the last read of the selected memory.
   assign sel_q = ram_rd_ff ? ram_q_ff : (rom_rd_ff ? rom_q_ff : 8'h00);

   // Transaction context and low byte of a short read.
   always_ff @(posedge clock) begin
      if (cmd.first) begin
         status_ff  <= status_in;
         ram_rd_ff  <= ram_rd;
         rom_rd_ff  <= rom_rd;
         two_ff     <= is_short && (ram_rd || rom_rd);
         ram_two_ff <= is_acc && is_short && in_ram;
         rom_two_ff <= is_short && rom_rd;
         wr_ff      <= is_wr;
         m1_ff      <= m0 + RAM_AW'(1);
         o1_ff      <= o1;
         hi_data_ff <= req_data[15:8];
      end
      if (cmd.second) begin
         lo_ff <= sel_q;
      end
   end

   // Clear counter and bank count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         banks_ff     <= cbmm_pkg::BANKS_RESET;
      end else begin
         if (cmd.clear) begin
            clear_cnt_ff <= clear_cnt_ff + RAM_AW'(1);
         end
         if (csr_write_enable) begin
            banks_ff <= csr_write_data;
         end
      end
   end

   // Result register; it frees when the transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_read_data_ff <= two_ff ? {sel_q, lo_ff} : {8'h00, sel_q};
         rsp_status_ff    <= status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;

   assign stat.clear_last   = (clear_cnt_ff == RAM_LAST);
   assign stat.needs_second = is_acc && is_short && (in_ram || (in_rom && !is_wr));
   assign stat.out_busy     = rsp_valid_ff && rsp_stall;

endmodule

### rtl/cpu_bus_memory_map.sv
// CPU bus memory map top level: controller plus datapath.
// Each transaction is a byte read or write, a little-endian short read or write, or a program
// ROM load byte. Work RAM and program ROM each have one memory port with a registered read,
// so a short transaction that reaches RAM, or a short ROM read, passes through a second access
// state before its result is loaded, because its two bytes go through that port one after the
// other. A new transaction is accepted while the previous result waits in the output register.
// After reset the block clears all RAM_BYTES entries of the work RAM (2048 by default), one
// entry a cycle, with req_stall high; bank count writes are taken during that pass.
module cpu_bus_memory_map #(
   parameter int RAM_BYTES  = cbmm_pkg::RAM_BYTES_DEFAULT,
   parameter int BANK_BYTES = cbmm_pkg::BANK_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [15:0] req_data,
   input  logic [14:0] req_load_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data
);

   cbmm_pkg::cbmm_cmd_type  cmd;
   cbmm_pkg::cbmm_stat_type stat;

   // Sequencing of each transaction and of the clearing pass.
   cbmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Decode, memories and result register.
   cbmm_datapath #(
      .RAM_BYTES  (RAM_BYTES),
      .BANK_BYTES (BANK_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_data         (req_data),
      .req_load_offset  (req_load_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule

### test/cpu_bus_memory_map_tb.sv
// Self-checking testbench for the CPU bus memory map: directed table, then random traffic.
`timescale 1ns / 1ps

module cpu_bus_memory_map_tb;
   import cbmm_pkg::*;

   // Kinds that the block must answer with an empty OK reply.
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

   localparam int          ROM_BYTES       = 2 * BANK_BYTES_DEFAULT;
   localparam logic [14:0] ONE_BANK_MASK   = 15'h3FFF;
   localparam logic [14:0] TWO_BANK_MASK   = 15'h7FFF;
   localparam int          NUM_PHASES      = 6;
   localparam int          PHASE_ITEMS     = 200;
   localparam int          QUIET_ITEMS     = 150;
   localparam int          HOLD_OFF_CYCLES = 60;
   localparam int          DRAIN_CYCLES    = 8;
   // Longest quiet stretch is the RAM clear pass after reset.
   localparam int          STALL_LIMIT     = 8000;

   typedef struct packed {
      logic [15:0] read_data;
      logic [1:0]  status;
   } bus_reply_t;

   localparam bus_reply_t REPLY_OK        = '{16'h0000, STATUS_OK};
   localparam bus_reply_t REPLY_PPU       = '{16'h0000, STATUS_PPU};
   localparam bus_reply_t REPLY_ROM_WRITE = '{16'h0000, STATUS_ROM_WRITE};
   localparam bus_reply_t REPLY_UNMAPPED  = '{16'h0000, STATUS_UNMAPPED};

   typedef enum logic {ROW_ACCESS, ROW_BANKS} row_op_e;

   typedef struct packed {
      row_op_e     op;
      logic [2:0]  kind;
      logic [15:0] addr;
      logic [15:0] data;
      logic [14:0] loff;
      logic [1:0]  banks;
      logic        typed;   // reply is given in the row instead of predicted
      bus_reply_t  want;
   } stim_row_t;

   // Directed rows: reset contents, mirrors, wraps, every window, every access kind and a spare kind.
   localparam stim_row_t DIRECTED_ROWS [0:26] = '{
      '{ROW_ACCESS, KIND_READ_BYTE,   16'h0000, 16'h0000, 15'h0000, 2'd0, 1'b1, REPLY_OK},
      '{ROW_ACCESS, KIND_READ_SHORT,  16'h1FFF, 16'h0000, 15'h0000, 2'd0, 1'b1, REPLY_OK},
      '{ROW_ACCESS, KIND_WRITE_BYTE,  16'h0000, 16'hFFFF, 15'h0000, 2'd0, 1'b1, REPLY_OK},
      '{ROW_ACCESS, KIND_WRITE_SHORT, 16'h07FF, 16'hA55A, 15'h0000, 2'd0, 1'b1, REPLY_OK},
      '{ROW_ACCESS, KIND_READ_SHORT,  16'h1FFF, 16'h0000, 15'h0000, 2'd0, 1'b0, REPLY_OK},
      '{ROW_ACCESS, KIND_READ_BYTE,   16'h1800, 16'h0000, 15'h0000, 2'd0, 1'b0, REPLY_OK},
      '{ROW_ACCESS, KIND_WRITE_BYTE,  16'h2000, 16'hFFFF, 15'h0000, 2'd0, 1'b1, REPLY_PPU},
      '{ROW_ACCESS, KIND_READ_SHORT,  16'h3FFF, 16'h0000, 15'h0000, 2'd0, 1'b1, REPLY_PPU},
      '{ROW_ACCESS, KIND_WRITE_SHORT, 16'h3FFF, 16'hFFFF, 15'h0000, 2'd0, 1'b1, REPLY_PPU},
      '{ROW_ACCESS, KIND_READ_BYTE,   16'h4000, 16'h0000, 15'h0000, 2'd0, 1'b1, REPLY_UNMAPPED},
      '{ROW_ACCESS, KIND_WRITE_SHORT, 16'h7FFF, 16'hFFFF, 15'h0000, 2'd0, 1'b1, REPLY_UNMAPPED},
      '{ROW_ACCESS, KIND_WRITE_BYTE,  16'h8000, 16'hFFFF, 15'h0000, 2'd0, 1'b1, REPLY_ROM_WRITE},
      '{ROW_ACCESS, KIND_WRITE_SHORT, 16'hFFFF, 16'hFFFF, 15'h0000, 2'd0, 1'b1, REPLY_ROM_WRITE},
      '{ROW_ACCESS, KIND_LOAD_ROM,    16'h0000, 16'h12C3, 15'h7FFF, 2'd0, 1'b1, REPLY_OK},
      '{ROW_ACCESS, KIND_LOAD_ROM,    16'hFFFF, 16'hFF3C, 15'h0000, 2'd0, 1'b1, REPLY_OK},
      '{ROW_ACCESS, KIND_LOAD_ROM,    16'h2000, 16'h0081, 15'h3FFF, 2'd0, 1'b1, REPLY_OK},
      '{ROW_ACCESS, KIND_LOAD_ROM,    16'h8000, 16'h007E, 15'h4000, 2'd0, 1'b1, REPLY_OK},
      '{ROW_ACCESS, KIND_READ_SHORT,  16'hFFFF, 16'h0000, 15'h0000, 2'd0, 1'b0, REPLY_OK},
      '{ROW_ACCESS, KIND_READ_BYTE,   16'hC000, 16'h0000, 15'h0000, 2'd0, 1'b0, REPLY_OK},
      '{ROW_ACCESS, KIND_SPARE_LAST,  16'hFFFF, 16'hFFFF, 15'h7FFF, 2'd0, 1'b1, REPLY_OK},
      '{ROW_BANKS,  KIND_READ_BYTE,   16'h0000, 16'h0000, 15'h0000, BANKS_ONE, 1'b0, REPLY_OK},
      '{ROW_ACCESS, KIND_READ_SHORT,  16'hBFFF, 16'h0000, 15'h0000, 2'd0, 1'b0, REPLY_OK},
      '{ROW_ACCESS, KIND_READ_SHORT,  16'hFFFF, 16'h0000, 15'h0000, 2'd0, 1'b0, REPLY_OK},
      '{ROW_ACCESS, KIND_READ_BYTE,   16'hC000, 16'h0000, 15'h0000, 2'd0, 1'b0, REPLY_OK},
      // An odd bank count of three behaves like two banks.
      '{ROW_BANKS,  KIND_READ_BYTE,   16'h0000, 16'h0000, 15'h0000, 2'd3, 1'b0, REPLY_OK},
      '{ROW_ACCESS, KIND_READ_BYTE,   16'hC000, 16'h0000, 15'h0000, 2'd0, 1'b0, REPLY_OK},
      '{ROW_ACCESS, KIND_READ_SHORT,  16'hFFFF, 16'h0000, 15'h0000, 2'd0, 1'b0, REPLY_OK}
   };

   // Bank count for each random phase, the extremes among them.
   localparam logic [1:0] PHASE_BANKS [0:NUM_PHASES-1] =
      '{BANKS_RESET, BANKS_ONE, 2'd0, 2'd3, BANKS_ONE, BANKS_RESET};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_kind;
   logic [15:0] req_address;
   logic [15:0] req_data;
   logic [14:0] req_load_offset;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_read_data;
   logic [1:0]  rsp_status;
   logic        csr_write_enable;
   logic [1:0]  csr_write_data;

   // Shadow copy of the memories and the bank count register.
   logic [7:0]  ram_image [0:RAM_BYTES_DEFAULT-1];
   logic [7:0]  rom_image [0:ROM_BYTES-1];
   bit          rom_filled [0:ROM_BYTES-1];
   logic [1:0]  bank_count;

   bus_reply_t  expected_replies [$];
   logic [14:0] rom_loaded [$];
   logic [10:0] ram_recent [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          send_mode = 1;
   bit          quiet_tail = 1'b0;
   bit          hold_off_request = 1'b0;

   cpu_bus_memory_map u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_data         (req_data),
      .req_load_offset  (req_load_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offset mask of the program ROM under the current bank count.
   function automatic logic [14:0] rom_mask();
      return (bank_count == BANKS_ONE) ? ONE_BANK_MASK : TWO_BANK_MASK;
   endfunction

   // Applies one transaction to the shadow memories and returns its reply.
   function automatic bus_reply_t predict_access(input logic [2:0] kind,
                                                 input logic [15:0] addr,
                                                 input logic [15:0] data,
                                                 input logic [14:0] loff);
      bus_reply_t  reply;
      logic [10:0] ram_lo, ram_hi;
      logic [14:0] rom_lo, rom_hi;
      reply = REPLY_OK;
      if (kind == KIND_LOAD_ROM) begin
         rom_image[loff] = data[7:0];
      end else if (kind <= KIND_WRITE_SHORT) begin
         if (addr[15:13] == WINDOW_RAM) begin
            ram_lo = addr[10:0];
            ram_hi = ram_lo + 11'd1;
            if (kind == KIND_WRITE_BYTE || kind == KIND_WRITE_SHORT) begin
               ram_image[ram_lo] = data[7:0];
               if (kind == KIND_WRITE_SHORT) ram_image[ram_hi] = data[15:8];
            end else begin
               reply.read_data[7:0] = ram_image[ram_lo];
               if (kind == KIND_READ_SHORT) reply.read_data[15:8] = ram_image[ram_hi];
            end
         end else if (addr[15:13] == WINDOW_PPU) begin
            reply.status = STATUS_PPU;
         end else if (addr[15]) begin
            if (kind == KIND_WRITE_BYTE || kind == KIND_WRITE_SHORT) begin
               reply.status = STATUS_ROM_WRITE;
            end else begin
               rom_lo = addr[14:0] & rom_mask();
               rom_hi = (rom_lo + 15'd1) & rom_mask();
               reply.read_data[7:0] = rom_image[rom_lo];
               if (kind == KIND_READ_SHORT) reply.read_data[15:8] = rom_image[rom_hi];
            end
         end else begin
            reply.status = STATUS_UNMAPPED;
         end
      end
      return reply;
   endfunction

   // Picks a ROM read address whose bytes have all been loaded.
   function automatic bit choose_rom_read(input bit two_bytes, output logic [15:0] addr);
      logic [14:0] offset;
      addr = 16'h8000;
      for (int i = 0; i < 16; i++) begin
         if (rom_loaded.size() == 0) return 1'b0;
         offset = rom_loaded[$urandom_range(0, rom_loaded.size() - 1)];
         if ((offset & rom_mask()) != offset) continue;
         if (two_bytes && !rom_filled[(offset + 15'd1) & rom_mask()]) continue;
         addr = {1'b1, offset};
         // With one bank either half of the window reaches the same byte.
         if (bank_count == BANKS_ONE) addr[14] = 1'($urandom_range(0, 1));
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Offers one transaction, waits for it to be taken and records its reply.
   task automatic issue(input logic [2:0] kind, input logic [15:0] addr,
                        input logic [15:0] data, input logic [14:0] loff,
                        input bit typed = 1'b0, input bus_reply_t want = REPLY_OK);
      bus_reply_t predicted;
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_address     <= addr;
      req_data        <= data;
      req_load_offset <= loff;
      do @(posedge clock); while (req_stall);
      predicted = predict_access(kind, addr, data, loff);
      expected_replies.push_back(typed ? want : predicted);
      if (kind == KIND_LOAD_ROM) begin
         rom_filled[loff] = 1'b1;
         rom_loaded.push_back(loff);
      end
   endtask

   // Occasional random idle gap on the request side; none in the quiet tail or in send mode 0.
   task automatic sender_gap();
      if (quiet_tail || send_mode == 0) return;
      if ($urandom_range(0, (send_mode == 1) ? 7 : 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Waits until the block is empty, then writes the bank count register.
   task automatic write_bank_count(input logic [1:0] value);
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      bank_count = value;
   endtask

   // One random transaction; spare kinds do not count as work.
   task automatic random_access(output bit counted);
      logic [2:0]  kind;
      logic [15:0] addr;
      logic [15:0] data;
      logic [14:0] loff;
      int          pick;
      int          ram_sel;
      addr    = 16'($urandom);
      data    = 16'($urandom);
      loff    = 15'($urandom);
      kind    = KIND_READ_BYTE;
      counted = 1'b1;
      pick    = $urandom_range(0, 99);
      if (pick < 40) begin
         // Work RAM: favor recently written bytes and the wrap offset.
         kind    = 3'($urandom_range(KIND_READ_BYTE, KIND_WRITE_SHORT));
         ram_sel = $urandom_range(0, 3);
         if (ram_sel == 1 && ram_recent.size() != 0)
            addr = {WINDOW_RAM, addr[12:11], ram_recent[$urandom_range(0, ram_recent.size() - 1)]};
         else if (ram_sel == 0)
            addr = {WINDOW_RAM, addr[12:11], 11'h7FF};
         else
            addr = {WINDOW_RAM, addr[12:0]};
      end else if (pick < 60) begin
         kind = $urandom_range(0, 1) ? KIND_READ_SHORT : KIND_READ_BYTE;
         // Nothing readable yet: load a byte instead.
         if (!choose_rom_read(kind == KIND_READ_SHORT, addr)) kind = KIND_LOAD_ROM;
      end else if (pick < 75) begin
         kind = KIND_LOAD_ROM;
         // Runs of consecutive offsets make short reads possible.
         if (rom_loaded.size() != 0 && $urandom_range(0, 1))
            loff = rom_loaded[rom_loaded.size() - 1] + 15'd1;
      end else if (pick < 82) begin
         kind = 3'($urandom_range(KIND_READ_BYTE, KIND_WRITE_SHORT));
         addr = {WINDOW_PPU, addr[12:0]};
      end else if (pick < 88) begin
         kind = 3'($urandom_range(KIND_READ_BYTE, KIND_WRITE_SHORT));
         addr = {2'b01, addr[13:0]};
      end else if (pick < 94) begin
         kind = $urandom_range(0, 1) ? KIND_WRITE_SHORT : KIND_WRITE_BYTE;
         addr = {1'b1, addr[14:0]};
      end else begin
         kind    = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
         counted = 1'b0;
      end
      issue(kind, addr, data, loff);
      if (addr[15:13] == WINDOW_RAM && (kind == KIND_WRITE_BYTE || kind == KIND_WRITE_SHORT)) begin
         ram_recent.push_back(addr[10:0]);
         if (ram_recent.size() > 16) void'(ram_recent.pop_front());
      end
   endtask

   // Compares one reply with the oldest outstanding transaction.
   task automatic check_reply(input logic [15:0] read_data, input logic [1:0] status);
      bus_reply_t want;
      if (expected_replies.size() == 0) begin
         $error("reply with no transaction outstanding: read_data %h status %0d",
                read_data, status);
         mismatches++;
         return;
      end
      want = expected_replies.pop_front();
      if (read_data !== want.read_data) begin
         $error("read_data: expected %h, got %h", want.read_data, read_data);
         mismatches++;
      end
      if (status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, status);
         mismatches++;
      end
   endtask

   // Reply side: check accepted transactions and stall in random bursts.
   initial begin
      int stall_left;
      int recv_mode;
      int mode_left;
      bit hold_done;
      stall_left = 0;
      recv_mode  = 1;
      mode_left  = 0;
      hold_done  = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_reply(rsp_read_data, rsp_status);
         if (mode_left == 0) begin
            recv_mode = $urandom_range(0, 2);
            mode_left = 64;
         end
         mode_left--;
         // One long hold-off so that the block fills up and stalls its input.
         if (hold_off_request && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && recv_mode != 0 &&
                      $urandom_range(0, (recv_mode == 1) ? 9 : 3) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles in which neither side moves a transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
         $display("cpu_bus_memory_map verification failed");
         $finish;
      end
   end

   // Request side: reset, directed table, random phases, then drain.
   initial begin
      int n;
      bit counted;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_kind         <= KIND_READ_BYTE;
      req_address      <= '0;
      req_data         <= '0;
      req_load_offset  <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      foreach (ram_image[i]) ram_image[i] = '0;
      bank_count = BANKS_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].op == ROW_BANKS) begin
            write_bank_count(DIRECTED_ROWS[i].banks);
         end else begin
            issue(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].data,
                  DIRECTED_ROWS[i].loff, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
            sender_gap();
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_bank_count(PHASE_BANKS[p]);
         n = 0;
         while (n < PHASE_ITEMS) begin
            if (n % 40 == 0) send_mode = $urandom_range(0, 2);
            if (p == 2 && n == 50) hold_off_request = 1'b1;
            if (p == NUM_PHASES - 1 && n == PHASE_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            random_access(counted);
            if (counted) n++;
            sender_gap();
         end
      end

      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("cpu_bus_memory_map verification clean");
      end else begin
         $display("cpu_bus_memory_map verification failed");
      end
      $finish;
   end

endmodule

### cpu_bus_memory_map.f
rtl/cbmm_pkg.sv
rtl/cbmm_ctrl.sv
rtl/cbmm_datapath.sv
rtl/cpu_bus_memory_map.sv
test/cpu_bus_memory_map_tb.sv
